// File: hdl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, codes and controller/datapath interface types for the
// cave automaton smoother.
// ----------------------------------------------------------------------------
package cas_pkg;

  // grid storage: one memory word per column, one bit per row
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register field widths
  localparam int DIM_W    = 7;
  localparam int THR_W    = 4;
  localparam int PASSES_W = 8;
  localparam int CMD_W    = 2;

  // APB side
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // request commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_PASSES      = 2'd3;

  localparam logic [DIM_W-1:0]    GRID_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]    GRID_HEIGHT_RST = 7'd64;
  localparam logic [THR_W-1:0]    THRESHOLD_RST   = 4'd4;
  localparam logic [PASSES_W-1:0] PASSES_RST      = 8'd5;

  // memory read address source, relative to the column counter
  typedef enum logic [1:0] {
    RD_COL  = 2'd0,
    RD_NEXT = 2'd1,
    RD_SKIP = 2'd2
  } rd_src_t;

  // memory write data source
  typedef enum logic [1:0] {
    WR_ZERO = 2'd0,
    WR_CELL = 2'd1,
    WR_MID  = 2'd2
  } wr_src_t;

  // response payload kind
  typedef enum logic [1:0] {
    RSP_OK   = 2'd0,
    RSP_OOB  = 2'd1,
    RSP_CELL = 2'd2
  } rsp_kind_t;

  typedef struct packed {
    logic      ld_req;      // latch coordinates and cell value
    logic      col_clr;
    logic      col_inc;
    logic      row_clr;
    logic      row_inc;
    logic      rd_en;
    rd_src_t   rd_src;
    logic      wr_en;
    wr_src_t   wr_src;
    logic      win_init;    // left column := off-grid walls
    logic      mid_ld;
    logic      right_ld;
    logic      win_shift;
    logic      row_upd;
    logic      fixing;
    logic      rsp_ld;
    rsp_kind_t rsp_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic oob;
    logic grid_empty;
    logic row_last;
    logic col_last;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: hdl/cas_datapath.sv
// ----------------------------------------------------------------------------
// cas_datapath
// Column-organized cell memory, three-column sliding window, neighbor
// counter with smoothing/fixing rule, and the response payload registers.
// ----------------------------------------------------------------------------
module cas_datapath
  import cas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [COL_W-1:0]      in_col,
  input  logic [ROW_W-1:0]      in_row,
  input  logic                  in_cell_in,
  input  logic [DIM_W-1:0]      eff_w,
  input  logic [DIM_W-1:0]      eff_h,
  input  logic [THR_W-1:0]      threshold,
  output logic                  out_cell_out,
  output logic                  out_status
);

  logic [MAX_HEIGHT-1:0] mem [MAX_WIDTH];
  logic [MAX_HEIGHT-1:0] rdata_r;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  cell_r, cell_nxt;
  logic [MAX_HEIGHT-1:0] left_r, left_nxt;
  logic [MAX_HEIGHT-1:0] mid_r, mid_nxt;
  logic [MAX_HEIGHT-1:0] right_r, right_nxt;
  logic                  cell_out_r, cell_out_nxt;
  logic                  status_r, status_nxt;

  logic [COL_W-1:0]      rd_addr;
  logic [MAX_HEIGHT-1:0] wr_data;
  logic [MAX_HEIGHT-1:0] cell_word;
  logic [DIM_W-1:0]      col_ext, row_ext;
  logic [DIM_W-1:0]      col_p1, col_p2, row_p1;
  logic [ROW_W-1:0]      row_up, row_dn;
  logic                  up_ok, dn_ok;
  logic                  l_up, l_ct, l_dn, m_up, m_dn, r_up, r_ct, r_dn;
  logic [3:0]            cnt;
  logic                  new_bit;

  assign col_ext = {1'b0, col_r};
  assign row_ext = {1'b0, row_r};
  assign col_p1  = col_ext + 7'd1;
  assign col_p2  = col_ext + 7'd2;
  assign row_p1  = row_ext + 7'd1;

  // status
  assign stat.oob        = (col_ext >= eff_w) || (row_ext >= eff_h);
  assign stat.grid_empty = (eff_w == '0) || (eff_h == '0);
  assign stat.row_last   = (row_p1 == eff_h);
  assign stat.col_last   = (col_p1 == eff_w);
  assign stat.clr_last   = (col_r == COL_W'(MAX_WIDTH - 1));

  // memory addressing
  always_comb begin
    case (cmd.rd_src)
      RD_COL:  rd_addr = col_r;
      RD_NEXT: rd_addr = col_p1[COL_W-1:0];
      RD_SKIP: rd_addr = col_p2[COL_W-1:0];
      default: rd_addr = col_r;
    endcase
  end

  always_comb begin
    cell_word         = rdata_r;
    cell_word[row_r]  = cell_r;
    case (cmd.wr_src)
      WR_ZERO: wr_data = '0;
      WR_CELL: wr_data = cell_word;
      WR_MID:  wr_data = mid_r;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[col_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // 3x3 window around (col_r,row_r); off-grid positions read as wall
  assign row_up = row_r - 1'b1;
  assign row_dn = row_r + 1'b1;
  assign up_ok  = (row_r != '0);
  assign dn_ok  = (row_p1 < eff_h);

  assign l_up = up_ok ? left_r[row_up]  : 1'b1;
  assign l_ct = left_r[row_r];
  assign l_dn = dn_ok ? left_r[row_dn]  : 1'b1;
  assign m_up = up_ok ? mid_r[row_up]   : 1'b1;
  assign m_dn = dn_ok ? mid_r[row_dn]   : 1'b1;
  assign r_up = up_ok ? right_r[row_up] : 1'b1;
  assign r_ct = right_r[row_r];
  assign r_dn = dn_ok ? right_r[row_dn] : 1'b1;

  assign cnt = {3'b0, l_up} + {3'b0, l_ct} + {3'b0, l_dn} + {3'b0, m_up}
             + {3'b0, m_dn} + {3'b0, r_up} + {3'b0, r_ct} + {3'b0, r_dn};

  always_comb begin
    new_bit = mid_r[row_r];
    if (cmd.fixing ? (cnt > threshold) : (cnt == threshold)) begin
      new_bit = 1'b1;
    end else if (cnt < threshold) begin
      new_bit = 1'b0;
    end
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    cell_nxt     = cell_r;
    left_nxt     = left_r;
    mid_nxt      = mid_r;
    right_nxt    = right_r;
    cell_out_nxt = cell_out_r;
    status_nxt   = status_r;

    if (cmd.ld_req) begin
      col_nxt  = in_col;
      row_nxt  = in_row;
      cell_nxt = in_cell_in;
    end
    if (cmd.col_clr) begin
      col_nxt = '0;
    end else if (cmd.col_inc) begin
      col_nxt = col_r + 1'b1;
    end
    if (cmd.row_clr) begin
      row_nxt = '0;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + 1'b1;
    end

    if (cmd.win_init) begin
      left_nxt = '1;
    end
    if (cmd.mid_ld) begin
      mid_nxt = rdata_r;
    end
    if (cmd.right_ld) begin
      right_nxt = (col_p1 < eff_w) ? rdata_r : '1;
    end
    if (cmd.row_upd) begin
      mid_nxt[row_r] = new_bit;
    end
    if (cmd.win_shift) begin
      left_nxt  = mid_r;
      mid_nxt   = right_r;
      right_nxt = (col_p2 < eff_w) ? rdata_r : '1;
    end

    if (cmd.rsp_ld) begin
      case (cmd.rsp_kind)
        RSP_OK: begin
          cell_out_nxt = 1'b0;
          status_nxt   = 1'b0;
        end
        RSP_OOB: begin
          cell_out_nxt = 1'b0;
          status_nxt   = 1'b1;
        end
        RSP_CELL: begin
          cell_out_nxt = rdata_r[row_r];
          status_nxt   = 1'b0;
        end
        default: begin
          cell_out_nxt = 1'b0;
          status_nxt   = 1'b0;
        end
      endcase
    end
  end

  // the column coordinate doubles as the clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    left_r     <= left_nxt;
    mid_r      <= mid_nxt;
    right_r    <= right_nxt;
    cell_out_r <= cell_out_nxt;
    status_r   <= status_nxt;
  end

  assign out_cell_out = cell_out_r;
  assign out_status   = status_r;

endmodule

// File: hdl/cas_ctrl.sv
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer: clearing sweep, request handshake, cell access, and the
// column-by-column scan of each smoothing and fixing pass.
// ----------------------------------------------------------------------------
module cas_ctrl
  import cas_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [PASSES_W-1:0] smoothing_passes,
  input  dp_stat_t            stat,
  output ctl_cmd_t            cmd
);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_ACCESS    = 11'b000_0000_0100,
    S_MODIFY    = 11'b000_0000_1000,
    S_PASS_INIT = 11'b000_0001_0000,
    S_RD_MID    = 11'b000_0010_0000,
    S_RD_RIGHT  = 11'b000_0100_0000,
    S_LD_RIGHT  = 11'b000_1000_0000,
    S_ROW       = 11'b001_0000_0000,
    S_COL_END   = 11'b010_0000_0000,
    S_RESP      = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PASSES_W-1:0] pass_left_r, pass_left_nxt;
  logic                fixing_r, fixing_nxt;
  rsp_kind_t           kind_r, kind_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                accept;
  // true on the first row cycle of a column
  logic                row_first_r, row_first_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pass_left_nxt = pass_left_r;
    fixing_nxt    = fixing_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.fixing    = fixing_r;
    cmd.rsp_kind  = kind_r;

    case (state_r)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ZERO;
        cmd.col_inc = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd.ld_req = 1'b1;
          cmd_nxt    = in_cmd;
          if (in_cmd inside {CMD_WRITE, CMD_READ}) begin
            state_nxt = S_ACCESS;
          end else if (in_cmd == CMD_RUN && !stat.grid_empty) begin
            pass_left_nxt = smoothing_passes;
            fixing_nxt    = (smoothing_passes == '0);
            state_nxt     = S_PASS_INIT;
          end else begin
            kind_nxt  = RSP_OK;
            state_nxt = S_RESP;
          end
        end
      end

      S_ACCESS: begin
        if (stat.oob) begin
          kind_nxt  = RSP_OOB;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_COL;
          state_nxt  = S_MODIFY;
        end
      end

      S_MODIFY: begin
        if (cmd_r == CMD_WRITE) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_CELL;
          kind_nxt   = RSP_OK;
        end else begin
          kind_nxt   = RSP_CELL;
        end
        state_nxt = S_RESP;
      end

      S_PASS_INIT: begin
        cmd.col_clr  = 1'b1;
        cmd.row_clr  = 1'b1;
        cmd.win_init = 1'b1;
        state_nxt    = S_RD_MID;
      end

      S_RD_MID: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_COL;
        state_nxt  = S_RD_RIGHT;
      end

      S_RD_RIGHT: begin
        cmd.mid_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_NEXT;
        state_nxt  = S_LD_RIGHT;
      end

      S_LD_RIGHT: begin
        cmd.right_ld = 1'b1;
        state_nxt    = S_ROW;
      end

      S_ROW: begin
        cmd.row_upd = 1'b1;
        // prefetch the column two ahead for the next window shift
        cmd.rd_src = RD_SKIP;
        cmd.rd_en  = !stat.col_last && row_first_r;
        if (stat.row_last) begin
          cmd.row_clr = 1'b1;
          state_nxt   = S_COL_END;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end

      S_COL_END: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_src    = WR_MID;
        cmd.win_shift = 1'b1;
        if (!stat.col_last) begin
          cmd.col_inc = 1'b1;
          state_nxt   = S_ROW;
        end else if (fixing_r) begin
          kind_nxt  = RSP_OK;
          state_nxt = S_RESP;
        end else begin
          pass_left_nxt = pass_left_r - 1'b1;
          fixing_nxt    = (pass_left_r == 8'd1);
          state_nxt     = S_PASS_INIT;
        end
      end

      S_RESP: begin
        if (out_free) begin
          cmd.rsp_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    row_first_nxt = row_first_r;
    if (state_r == S_LD_RIGHT || state_r == S_COL_END) begin
      row_first_nxt = 1'b1;
    end else if (state_r == S_ROW) begin
      row_first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      row_first_r <= 1'b0;
      fixing_r    <= 1'b0;
      pass_left_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_first_r <= row_first_nxt;
      fixing_r    <= fixing_nxt;
      pass_left_r <= pass_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    kind_r <= kind_nxt;
  end

endmodule

// File: hdl/cave_automaton_smoother_top.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoother_top
// Wall/floor grid with cell access and cellular-automaton smoothing runs.
// ----------------------------------------------------------------------------
// Each request gives exactly one response. After reset the block clears the
// grid memory (one column word per cycle) before it takes its first request;
// register writes are taken during that time. A cell write or read checks the
// coordinate, reads the column word, writes it back for a write and then loads
// the response register; an off-grid coordinate, a run on an empty grid and
// the other commands go straight to the response. A run makes smoothing_passes
// smoothing passes and then one fixing pass: the grid lives in a single-port
// memory with one word per column, each pass slides a three-column window
// across it with one read and one write per column, and the neighbor count
// updates one row per cycle. Requests are taken one at a time; a response
// waiting in the output register does not block acceptance of the next request.
// ----------------------------------------------------------------------------
module cave_automaton_smoother_top
  import cas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic              in_cell_in,
  // response channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_cell_out,
  output logic              out_status,
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [DIM_W-1:0]    grid_width_r, grid_width_nxt;
  logic [DIM_W-1:0]    grid_height_r, grid_height_nxt;
  logic [THR_W-1:0]    threshold_r, threshold_nxt;
  logic [PASSES_W-1:0] passes_r, passes_nxt;
  logic [DIM_W-1:0]    eff_w, eff_h;
  logic                cfg_wr;
  ctl_cmd_t            cmd;
  dp_stat_t            stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    threshold_nxt   = threshold_r;
    passes_nxt      = passes_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = cfg_pwdata[DIM_W-1:0];
        REG_THRESHOLD:   threshold_nxt   = cfg_pwdata[THR_W-1:0];
        REG_PASSES:      passes_nxt      = cfg_pwdata[PASSES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_GRID_WIDTH:  cfg_prdata = {{(APB_DW-DIM_W){1'b0}}, grid_width_r};
      REG_GRID_HEIGHT: cfg_prdata = {{(APB_DW-DIM_W){1'b0}}, grid_height_r};
      REG_THRESHOLD:   cfg_prdata = {{(APB_DW-THR_W){1'b0}}, threshold_r};
      REG_PASSES:      cfg_prdata = {{(APB_DW-PASSES_W){1'b0}}, passes_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      threshold_r   <= THRESHOLD_RST;
      passes_r      <= PASSES_RST;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      threshold_r   <= threshold_nxt;
      passes_r      <= passes_nxt;
    end
  end

  // sizes above the storage limit act as the limit
  assign eff_w = (grid_width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_r;
  assign eff_h = (grid_height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height_r;

  cas_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .smoothing_passes (passes_r),
    .stat             (stat),
    .cmd              (cmd)
  );

  cas_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_cell_in   (in_cell_in),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .threshold    (threshold_r),
    .out_cell_out (out_cell_out),
    .out_status   (out_status)
  );

endmodule

// File: dv/cas_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cas_checker
// Watches the request, response and register ports of the cave automaton
// smoother. It keeps its own grid and register copy and predicts each
// response in order. Mismatches go into a failure count for the bench top.
// ----------------------------------------------------------------------------
module cas_checker
  import cas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic              in_cell_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_cell_out,
  input  logic              out_status,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic cell_out;
    logic status;
  } cell_rsp_t;

  cell_rsp_t             rsp_due_q[$];
  bit                    cave [MAX_WIDTH][MAX_HEIGHT];   // [col][row], 1 = wall
  logic [DIM_W-1:0]      width_r;
  logic [DIM_W-1:0]      height_r;
  logic [THR_W-1:0]      thr_r;
  logic [PASSES_W-1:0]   passes_r;
  int                    errors;

  function automatic int used_width();
    return (width_r > MAX_WIDTH) ? MAX_WIDTH : int'(width_r);
  endfunction

  function automatic int used_height();
    return (height_r > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_r);
  endfunction

  // walls in the 3x3 window around (c,r), off-grid positions count as walls
  function automatic int walls_around(int c, int r, int w, int h);
    int n;
    int x;
    int y;
    n = 0;
    for (int dc = -1; dc <= 1; dc++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        x = c + dc;
        y = r + dr;
        if (x < 0 || x >= w || y < 0 || y >= h) begin
          n++;
        end else if (dc != 0 || dr != 0) begin
          n += int'(cave[x][y]);
        end
      end
    end
    return n;
  endfunction

  // one in-place sweep, column outer, row inner
  function automatic void smooth_sweep(bit fixing);
    int w;
    int h;
    int t;
    int n;
    w = used_width();
    h = used_height();
    t = int'(thr_r);
    for (int c = 0; c < w; c++) begin
      for (int r = 0; r < h; r++) begin
        n = walls_around(c, r, w, h);
        if (fixing ? (n > t) : (n == t)) begin
          cave[c][r] = 1'b1;
        end else if (n < t) begin
          cave[c][r] = 1'b0;
        end
      end
    end
  endfunction

  function automatic cell_rsp_t predict_rsp(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                                            logic [ROW_W-1:0] row, logic cell_val);
    cell_rsp_t rsp;
    rsp.cell_out = 1'b0;
    rsp.status   = 1'b0;
    case (cmd)
      CMD_WRITE, CMD_READ: begin
        if (int'(col) >= used_width() || int'(row) >= used_height()) begin
          rsp.status = 1'b1;
        end else if (cmd == CMD_WRITE) begin
          cave[col][row] = cell_val;
        end else begin
          rsp.cell_out = cave[col][row];
        end
      end
      CMD_RUN: begin
        for (int p = 0; p < int'(passes_r); p++) smooth_sweep(1'b0);
        smooth_sweep(1'b1);
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    cell_rsp_t want;
    if (!rst_n) begin
      foreach (cave[c, r]) cave[c][r] = 1'b0;
      width_r  = GRID_WIDTH_RST;
      height_r = GRID_HEIGHT_RST;
      thr_r    = THRESHOLD_RST;
      passes_r = PASSES_RST;
      rsp_due_q.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_due_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] response with no request outstanding: cell_out %b status %b",
                     $time, out_cell_out, out_status);
          end
        end else begin
          want = rsp_due_q.pop_front();
          if (out_cell_out !== want.cell_out || out_status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] response mismatch: cell_out exp %b got %b, status exp %b got %b",
                       $time, want.cell_out, out_cell_out, want.status, out_status);
            end
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[APB_AW-1:2])
          REG_GRID_WIDTH:  width_r  = cfg_pwdata[DIM_W-1:0];
          REG_GRID_HEIGHT: height_r = cfg_pwdata[DIM_W-1:0];
          REG_THRESHOLD:   thr_r    = cfg_pwdata[THR_W-1:0];
          REG_PASSES:      passes_r = cfg_pwdata[PASSES_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        rsp_due_q.push_back(predict_rsp(in_cmd, in_col, in_row, in_cell_in));
      end
    end
    fail_count <= errors;
    pending    <= rsp_due_q.size();
  end

endmodule

// File: dv/tb_cave_automaton_smoother_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cave_automaton_smoother_top
// Stimulus and verdict for the cave automaton smoother. Directed cell
// accesses and runs over corner-case grid settings, then random phases of
// grid fills, runs and read-backs under bursty requests and response stalls.
// ----------------------------------------------------------------------------
module tb_cave_automaton_smoother_top;
  import cas_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RUN_BUDGET  = 12000;   // cycles allowed for one random run

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd = CMD_WRITE;
  logic [COL_W-1:0]  in_col = '0;
  logic [ROW_W-1:0]  in_row = '0;
  logic              in_cell_in = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_cell_out;
  logic              out_status;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending;

  int                cycle_count = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;

  cave_automaton_smoother_top uut (.*);
  cas_checker chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // response side stalls; the mode is redrawn whenever its countdown runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(10, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_left % 5) < 2);
      endcase
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input int col, input int row,
                      input bit cell_val);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_col     <= col[COL_W-1:0];
    in_row     <= row[ROW_W-1:0];
    in_cell_in <= cell_val;
    do @(posedge clk); while (in_stall);
  endtask

  // stop requesting and wait until every response has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int value, input int bits);
    logic [APB_DW-1:0] word;
    word = ($urandom_range(0, 1) == 1) ? $urandom() : '0;
    for (int i = 0; i < bits; i++) word[i] = value[i];
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input int w, input int h, input int thr, input int passes);
    reg_write(REG_GRID_WIDTH, w, DIM_W);
    reg_write(REG_GRID_HEIGHT, h, DIM_W);
    reg_write(REG_THRESHOLD, thr, THR_W);
    reg_write(REG_PASSES, passes, PASSES_W);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 64;
      4:       return $urandom_range(65, 127);
      5:       return $urandom_range(9, 40);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  initial begin
    int w;
    int h;
    int ew;
    int eh;
    int thr;
    int passes;
    int max_passes;
    int n;
    int pick;
    int col;
    int row;
    int rand_items;

    rand_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 64x64 grid, corners and a full default run
    send(CMD_WRITE, 0, 0, 1'b1);
    send(CMD_WRITE, 63, 63, 1'b1);
    send(CMD_WRITE, 5, 7, 1'b0);
    send(CMD_READ, 0, 0, 1'b0);
    send(CMD_READ, 63, 63, 1'b1);
    send(CMD_READ, 1, 1, 1'b0);
    send(CMD_NOP, 63, 63, 1'b1);
    send(CMD_RUN, 42, 21, 1'b1);
    send(CMD_READ, 0, 0, 1'b0);
    send(CMD_READ, 63, 63, 1'b0);

    // width above maximum, empty height, threshold above eight
    settle();
    set_grid(127, 0, 15, 0);
    send(CMD_WRITE, 0, 0, 1'b1);
    send(CMD_READ, 63, 0, 1'b0);
    send(CMD_RUN, 0, 0, 1'b0);

    // three by three grid, zero threshold, most passes
    settle();
    set_grid(3, 3, 0, 255);
    send(CMD_WRITE, 2, 2, 1'b1);
    send(CMD_WRITE, 3, 0, 1'b1);
    send(CMD_READ, 0, 3, 1'b0);
    send(CMD_RUN, 1, 1, 1'b0);
    send(CMD_READ, 1, 1, 1'b0);

    // one column wide grid, threshold eight
    settle();
    set_grid(1, 2, 8, 1);
    send(CMD_WRITE, 0, 1, 1'b1);
    send(CMD_RUN, 0, 0, 1'b1);
    send(CMD_READ, 0, 1, 1'b0);
    send(CMD_READ, 1, 0, 1'b0);

    while (rand_items < 400) begin
      settle();
      w  = pick_dim();
      h  = pick_dim();
      ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      thr = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      // keep every run within budget: big grids get few passes
      max_passes = RUN_BUDGET / (4 + ew * (eh + 1)) - 1;
      if (max_passes > 255) max_passes = 255;
      if (max_passes < 0) max_passes = 0;
      if ($urandom_range(0, 9) == 0) begin
        passes = max_passes;
      end else begin
        passes = $urandom_range(0, (max_passes < 6) ? max_passes : 6);
      end
      set_grid(w, h, thr, passes);

      // full fill, run, full read-back on small grids, chosen at random
      if (ew * eh > 0 && ew * eh <= 49 && $urandom_range(0, 9) < 5) begin
        for (int c = 0; c < ew; c++) begin
          for (int r = 0; r < eh; r++) send(CMD_WRITE, c, r, $urandom_range(0, 99) < 45);
        end
        send(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        for (int c = 0; c < ew; c++) begin
          for (int r = 0; r < eh; r++) send(CMD_READ, c, r, $urandom_range(0, 1));
        end
        rand_items += 2 * ew * eh + 1;
      end

      n = $urandom_range(20, 50);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        col = (ew == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, ew - 1);
        row = (eh == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, eh - 1);
        if (pick < 45) begin
          send(CMD_WRITE, col, row, $urandom_range(0, 1));
        end else if (pick < 53) begin
          send(CMD_RUN, col, row, $urandom_range(0, 1));
        end else if (pick < 93) begin
          send(CMD_READ, col, row, $urandom_range(0, 1));
        end else begin
          send(CMD_NOP, col, row, $urandom_range(0, 1));
        end
      end
      rand_items += n;
    end

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
